// ===== rtl/psg_pkg.sv =====
// Package with shared constants and types for the four-voice tone and noise generator.
package psg_pkg;

    localparam int SAMPLE_RATE = 44100;
    localparam int STEP_CLOCK  = 223722;

    localparam int QUO_W   = 18;
    localparam int CNT_W   = 5;
    localparam int PER_W   = 10;
    localparam int ACC_W   = 32;
    localparam int VOL_W   = 4;
    localparam int LFSR_W  = 15;

    localparam logic [ACC_W-1:0]  SAMPLE_RATE_W = ACC_W'(SAMPLE_RATE);
    localparam logic [QUO_W-1:0]  STEP_CLOCK_W  = QUO_W'(STEP_CLOCK);
    localparam logic [CNT_W-1:0]  DIV_LAST      = CNT_W'(QUO_W - 1);
    localparam logic [LFSR_W-1:0] LFSR_SEED     = 15'h4000;
    localparam logic [PER_W-1:0]  MIN_PERIOD    = 10'd5;
    localparam logic [7:0]        MIX_BIAS      = 8'h80;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] NOISE_VOICE = 2'd3;
    localparam logic [1:0] RATE_TONE2  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_DIV,
        S_SUB,
        S_WRAP,
        S_DONE
    } t_state;

endpackage

// ===== rtl/psg_tone_noise_synth_core.sv =====
// Top level of the four-voice tone and noise generator with a shared serial divider.
//
// A write transaction (tuser = 0) is decoded in the cycle it is accepted and the block is
// ready again on the next cycle. A tick transaction (tuser = 1) walks the four voices in
// order: each voice is checked and, if active, mixed in S_SEL, and an active voice then
// runs through the shared one-bit-per-cycle divider (S_DIV) that forms 223722 / period,
// then S_SUB subtracts the step and S_WRAP wraps the 32-bit phase accumulator. The sample
// is handed to an output register, so the next transaction can be taken while the
// previous sample still waits on the master side.
module psg_tone_noise_synth_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // Bits 7:0 hold data.
    input  logic       s_axis_tuser,   // Bit 0 holds op.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // Bits 7:0 hold sample.
);
    import psg_pkg::*;

    t_state r_state, n_state;

    logic [PER_W-1:0]  r_period [3];
    logic [PER_W-1:0]  n_period [3];
    logic [7:0]        r_rate, n_rate;
    logic [VOL_W-1:0]  r_vol [4];
    logic [VOL_W-1:0]  n_vol [4];
    logic [2:0]        r_pol, n_pol;
    logic [ACC_W-1:0]  r_acc [4];
    logic [ACC_W-1:0]  n_acc [4];
    logic [LFSR_W-1:0] r_lfsr, n_lfsr;
    logic              r_white, n_white;
    logic              r_follow, n_follow;
    logic [2:0]        r_latch, n_latch;
    logic [1:0]        r_voice, n_voice;
    logic [7:0]        r_mix, n_mix;
    logic [PER_W-1:0]  r_div, n_div;
    logic [PER_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_data, n_out_data;

    logic              in_fire;
    logic [PER_W-1:0]  cur_per;
    logic              cur_active;
    logic [PER_W:0]    trial;
    logic              trial_ok;
    logic              hit;
    logic              out_load;
    logic [2:0]        wr_latch;
    logic              wr_vol;
    logic [1:0]        wr_voice;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign cur_per = (r_voice != NOISE_VOICE) ? r_period[r_voice] :
                     (r_follow ? r_period[2] : {2'b00, r_rate});
    assign cur_active = (r_vol[r_voice] != '0) && (cur_per >= MIN_PERIOD);
    assign trial      = {r_rem, r_quo[QUO_W-1]};
    assign trial_ok   = (trial >= {1'b0, r_div});
    assign hit        = (r_acc[r_voice] == '0) || r_acc[r_voice][ACC_W-1];
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    assign wr_latch = s_axis_tdata[7] ? s_axis_tdata[6:4] : r_latch;
    assign wr_vol   = s_axis_tdata[7] ? s_axis_tdata[4] : r_latch[0];
    assign wr_voice = wr_latch[2:1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (s_axis_tuser == OP_TICK)) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (cur_active) begin
                    n_state = S_DIV;
                end else if (r_voice == NOISE_VOICE) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                n_state = S_WRAP;
            end
            S_WRAP: begin
                n_state = (r_voice == NOISE_VOICE) ? S_DONE : S_SEL;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_period    = r_period;
        n_rate      = r_rate;
        n_vol       = r_vol;
        n_pol       = r_pol;
        n_acc       = r_acc;
        n_lfsr      = r_lfsr;
        n_white     = r_white;
        n_follow    = r_follow;
        n_latch     = r_latch;
        n_voice     = r_voice;
        n_mix       = r_mix;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_data  = r_out_data;
        n_out_valid = (r_out_valid && !m_axis_tready) || out_load;
        unique case (r_state)
            S_IDLE: begin
                n_voice = 2'd0;
                n_mix   = MIX_BIAS;
                if (in_fire && (s_axis_tuser == OP_WRITE)) begin
                    n_latch = wr_latch;
                    if (wr_vol) begin
                        n_vol[wr_voice] = ~s_axis_tdata[3:0];
                    end else if (wr_voice != NOISE_VOICE) begin
                        if (s_axis_tdata[7]) begin
                            n_period[wr_voice] = {r_period[wr_voice][9:4], s_axis_tdata[3:0]};
                        end else begin
                            n_period[wr_voice] = {s_axis_tdata[5:0], r_period[wr_voice][3:0]};
                        end
                    end else begin
                        n_lfsr   = LFSR_SEED;
                        n_white  = s_axis_tdata[2];
                        n_follow = (s_axis_tdata[1:0] == RATE_TONE2);
                        n_rate   = 8'(8'd16 << s_axis_tdata[1:0]);
                    end
                end
            end
            S_SEL: begin
                if (cur_active) begin
                    if (r_voice == NOISE_VOICE) begin
                        n_mix = r_lfsr[0] ? r_mix + 8'(r_vol[r_voice])
                                          : r_mix - 8'(r_vol[r_voice]);
                    end else begin
                        n_mix = r_pol[r_voice] ? r_mix - 8'(r_vol[r_voice])
                                               : r_mix + 8'(r_vol[r_voice]);
                    end
                    n_div = cur_per;
                    n_rem = '0;
                    n_quo = STEP_CLOCK_W;
                    n_cnt = '0;
                end else if (r_voice != NOISE_VOICE) begin
                    n_voice = r_voice + 2'd1;
                end
            end
            S_DIV: begin
                n_rem = trial_ok ? PER_W'(trial - {1'b0, r_div}) : trial[PER_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], trial_ok};
                n_cnt = r_cnt + CNT_W'(1);
            end
            S_SUB: begin
                n_acc[r_voice] = r_acc[r_voice] - ACC_W'(r_quo);
            end
            S_WRAP: begin
                if (hit) begin
                    n_acc[r_voice] = r_acc[r_voice] + SAMPLE_RATE_W;
                    if (r_voice == NOISE_VOICE) begin
                        n_lfsr = {(r_white & r_lfsr[1]) ^ r_lfsr[0], r_lfsr[LFSR_W-1:1]};
                    end else begin
                        n_pol[r_voice] = ~r_pol[r_voice];
                    end
                end
                if (r_voice != NOISE_VOICE) begin
                    n_voice = r_voice + 2'd1;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_data = r_mix;
                end
            end
            default: begin
                n_voice = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= '{default: '0};
            r_rate      <= '0;
            r_vol       <= '{default: '0};
            r_pol       <= '0;
            r_acc       <= '{default: SAMPLE_RATE_W};
            r_lfsr      <= LFSR_SEED;
            r_white     <= 1'b0;
            r_follow    <= 1'b0;
            r_latch     <= '0;
            r_voice     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_rate      <= n_rate;
            r_vol       <= n_vol;
            r_pol       <= n_pol;
            r_acc       <= n_acc;
            r_lfsr      <= n_lfsr;
            r_white     <= n_white;
            r_follow    <= n_follow;
            r_latch     <= n_latch;
            r_voice     <= n_voice;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mix      <= n_mix;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the four-voice tone and noise generator core.
`timescale 1ns / 100ps

module tb_top;
    import psg_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_psg_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // Bits 7:0 hold data.
    logic       s_axis_tuser = OP_WRITE; // Bit 0 holds op.
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // Bits 7:0 hold sample.

    t_psg_item  pending_items[$];
    logic [7:0] expected_samples[$];
    int         error_count = 0;
    int         item_total = 0;
    int         send_gap = 0;
    int         recv_stall = 0;
    bit         steady = 1'b0;

    logic [9:0]        tone_per [3] = '{default: '0};
    logic [3:0]        voice_vol [4] = '{default: '0};
    logic              tone_neg [3] = '{default: 1'b0};
    logic [ACC_W-1:0]  phase [4] = '{default: SAMPLE_RATE_W};
    logic [7:0]        noise_rate = '0;
    logic [LFSR_W-1:0] lfsr = LFSR_SEED;
    logic              white = 1'b0;
    logic              noise_tone2 = 1'b0;
    logic [2:0]        latch_sel = '0;

    psg_tone_noise_synth_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic phase_hit(int v, logic [9:0] per);
        logic [ACC_W-1:0] acc;
        logic             hit;
        acc = phase[v] - (ACC_W'(STEP_CLOCK) / {22'd0, per});
        hit = (acc == '0) || acc[ACC_W-1];
        if (hit) begin
            acc = acc + SAMPLE_RATE_W;
        end
        phase[v] = acc;
        return hit;
    endfunction

    function automatic void apply_command(logic [7:0] d);
        logic       vol_wr;
        logic [1:0] v;
        if (d[7]) begin
            latch_sel = d[6:4];
            vol_wr = d[4];
        end else begin
            vol_wr = latch_sel[0];
        end
        v = latch_sel[2:1];
        if (vol_wr) begin
            voice_vol[v] = ~d[3:0];
        end else if (v != NOISE_VOICE) begin
            if (d[7]) begin
                tone_per[v] = {tone_per[v][9:4], d[3:0]};
            end else begin
                tone_per[v] = {d[5:0], tone_per[v][3:0]};
            end
        end else begin
            lfsr = LFSR_SEED;
            white = d[2];
            noise_tone2 = (d[1:0] == RATE_TONE2);
            noise_rate = 8'(16 << d[1:0]);
        end
    endfunction

    function automatic logic [7:0] synth_sample();
        logic [7:0] mix;
        logic [9:0] per;
        mix = MIX_BIAS;
        for (int v = 0; v < 3; v++) begin
            if (voice_vol[v] != '0 && tone_per[v] >= MIN_PERIOD) begin
                mix = tone_neg[v] ? mix - 8'(voice_vol[v]) : mix + 8'(voice_vol[v]);
                if (phase_hit(v, tone_per[v])) begin
                    tone_neg[v] = !tone_neg[v];
                end
            end
        end
        per = noise_tone2 ? tone_per[2] : {2'b00, noise_rate};
        if (voice_vol[3] != '0 && per >= MIN_PERIOD) begin
            mix = lfsr[0] ? mix + 8'(voice_vol[3]) : mix - 8'(voice_vol[3]);
            if (phase_hit(3, per)) begin
                lfsr = {lfsr[0] ^ (white & lfsr[1]), lfsr[LFSR_W-1:1]};
            end
        end
        return mix;
    endfunction

    function automatic logic [7:0] latch_byte(logic [1:0] voice, logic vol, logic [3:0] nib);
        return {1'b1, voice, vol, nib};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_write(logic [7:0] b);
        pending_items.push_back(t_psg_item'{op: OP_WRITE, data: b});
        item_total++;
    endtask

    task automatic queue_ticks(int n);
        repeat (n) begin
            pending_items.push_back(t_psg_item'{op: OP_TICK, data: 8'($urandom_range(0, 255))});
            item_total++;
        end
    endtask

    task automatic queue_period(logic [1:0] v, logic [9:0] p);
        queue_write(latch_byte(v, 1'b0, p[3:0]));
        queue_write({1'b0, 1'($urandom_range(0, 1)), p[9:4]});
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            steady <= !steady;
        end
    end

    always @(posedge i_clk) begin : stimulus_driver
        t_psg_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() != 0) begin
                item = pending_items.pop_front();
                s_axis_tuser <= item.op;
                s_axis_tdata <= item.data;
                s_axis_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : sink_driver
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall <= 0;
        end else if (recv_stall != 0) begin
            m_axis_tready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                recv_stall <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : sample_monitor
        logic [7:0] want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == OP_TICK) begin
                    expected_samples.push_back(synth_sample());
                end else begin
                    apply_command(s_axis_tdata);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d with none pending", m_axis_tdata));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== want) begin
                        report_mismatch($sformatf("sample %0d, predicted %0d",
                                                  m_axis_tdata, want));
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : test_sequence
        int         r;
        logic [1:0] v;
        logic [9:0] p;

        // Silent start, then the shortest audible period on tone 0 at full volume.
        queue_ticks(1);
        queue_period(2'd0, 10'd5);
        queue_write(latch_byte(2'd0, 1'b1, 4'h0));
        queue_ticks(2);
        // A period just below the audible floor keeps tone 1 frozen.
        queue_period(2'd1, 10'd4);
        queue_write(latch_byte(2'd1, 1'b1, 4'h0));
        queue_period(2'd2, 10'd1023);
        queue_write(latch_byte(2'd2, 1'b1, 4'h8));
        queue_ticks(1);
        // Noise: white at the fastest rate, then periodic and white tied to tone 2.
        queue_write(latch_byte(NOISE_VOICE, 1'b0, 4'b0100));
        queue_write(latch_byte(NOISE_VOICE, 1'b1, 4'h0));
        queue_ticks(2);
        queue_write(latch_byte(NOISE_VOICE, 1'b0, {2'b00, RATE_TONE2}));
        queue_ticks(1);
        queue_write(8'h05);
        queue_write(latch_byte(NOISE_VOICE, 1'b0, 4'b1111));
        queue_write(latch_byte(NOISE_VOICE, 1'b0, 4'b0001));
        queue_write(8'h7E);
        queue_ticks(1);
        queue_write(latch_byte(2'd0, 1'b1, 4'hF));
        queue_ticks(1);

        while (item_total < 700) begin
            r = $urandom_range(0, 99);
            v = 2'($urandom_range(0, 3));
            if (r < 25) begin
                p = ($urandom_range(0, 99) < 80) ? 10'($urandom_range(0, 60))
                                                 : 10'($urandom_range(0, 1023));
                queue_period(2'($urandom_range(0, 2)), p);
            end else if (r < 38) begin
                if ($urandom_range(0, 1) != 0) begin
                    queue_write(latch_byte(v, 1'b1, 4'($urandom_range(0, 15))));
                end else begin
                    queue_write(latch_byte(v, 1'b1, 4'($urandom_range(0, 15))));
                    queue_write({1'b0, 7'($urandom_range(0, 127))});
                end
            end else if (r < 45) begin
                queue_write(latch_byte(NOISE_VOICE, 1'b0, 4'($urandom_range(0, 15))));
            end else if (r < 52) begin
                queue_write(8'($urandom_range(0, 255)));
            end else begin
                queue_ticks($urandom_range(1, 20));
            end
        end

        while (!i_rst_n || pending_items.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);

        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

endmodule

// ===== sim.f =====
rtl/psg_pkg.sv
rtl/psg_tone_noise_synth_core.sv
verif/tb_top.sv
